[hw/rtl/sfl_pkg.sv]
// Shared constants and request kind codes for the slot free-list store.
// No dependencies; used by the core and by sfl_recov.
package sfl_pkg;

   localparam int SLOTS_DEFAULT = 256;

   localparam int KIND_W  = 3;
   localparam int IDX_W   = 8;
   localparam int STAMP_W = 64;
   localparam int GRANT_W = 8;
   localparam int COUNT_W = 9;

   localparam logic [KIND_W-1:0] KIND_ACQUIRE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_COMMIT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PUBLISH = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_REBUILD = 3'd5;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

endpackage

[hw/rtl/slot_free_list_store_core.sv]
// Slot free-list store: sequencer, head and published-mark registers.
// Depends on sfl_pkg, sfl_slot_mem and sfl_recov.
// Sequence: a request is taken in ST_IDLE with the slot read; ST_EXEC writes back where
//   needed and registers the result strobe; busy in ST_EXEC, one request at a time (RMW).
// Rebuild: busy for the scan, one slot per cycle through the memory port.
// Reset: clearing pass over every slot (busy high), then head 0, mark 0.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
module slot_free_list_store_core #(
   parameter int SLOTS = sfl_pkg::SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [sfl_pkg::KIND_W-1:0]         req_kind,
   input  logic [sfl_pkg::IDX_W-1:0]          req_slot_index,
   input  logic signed [sfl_pkg::STAMP_W-1:0] req_seq_value,
   output logic                               rsp_valid,
   output logic                               rsp_status,
   output logic [sfl_pkg::GRANT_W-1:0]        rsp_granted_slot,
   output logic [sfl_pkg::COUNT_W-1:0]        rsp_recovered_count,
   output logic                               rsp_slot_is_live,
   output logic signed [sfl_pkg::STAMP_W-1:0] rsp_slot_stamp,
   output logic                               rsp_slot_recoverable,
   output logic signed [sfl_pkg::STAMP_W-1:0] rsp_published_mark
);

   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int LINK_W  = $clog2(SLOTS + 1);
   localparam int STAMP_W = sfl_pkg::STAMP_W;
   localparam int ENTRY_W = LINK_W + 1 + STAMP_W;
   localparam logic [ADDR_W-1:0] LAST  = ADDR_W'(SLOTS - 1);
   localparam logic [LINK_W-1:0] EMPTY = LINK_W'(SLOTS);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;
   localparam logic [1:0] ST_SCAN  = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [LINK_W-1:0]               head_ff, head_in;
   logic signed [STAMP_W-1:0]       pub_ff, pub_in;
   logic [sfl_pkg::KIND_W-1:0]      kind_ff;
   logic [ADDR_W-1:0]               idx_ff;
   logic                            idx_ok_ff;
   logic signed [STAMP_W-1:0]       seq_ff;
   logic [ADDR_W-1:0]               ptr_ff, ptr_in;
   logic [LINK_W-1:0]               scan_head_ff, scan_head_in;
   logic [LINK_W-1:0]               count_ff, count_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_status_ff, rsp_status_in;
   logic [sfl_pkg::GRANT_W-1:0]     rsp_granted_ff, rsp_granted_in;
   logic [sfl_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                            rsp_live_ff, rsp_live_in;
   logic signed [STAMP_W-1:0]       rsp_stamp_ff, rsp_stamp_in;
   logic                            rsp_rec_ff, rsp_rec_in;
   logic signed [STAMP_W-1:0]       rsp_pub_ff, rsp_pub_in;

   logic                            accept;
   logic                            req_idx_ok;
   logic                            head_empty;
   logic                            wr_en, rd_en;
   logic [ADDR_W-1:0]               wr_addr, rd_addr;
   logic [ENTRY_W-1:0]              wr_data, rd_data;
   logic [LINK_W-1:0]               rd_link;
   logic                            rd_live;
   logic signed [STAMP_W-1:0]       rd_stamp;
   logic                            rd_recoverable;
   logic [LINK_W-1:0]               count_plus;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign req_idx_ok = (int'(req_slot_index) < SLOTS);
   assign head_empty = (int'(head_ff) >= SLOTS);

   assign rd_link  = rd_data[ENTRY_W-1:STAMP_W+1];
   assign rd_live  = rd_data[STAMP_W];
   assign rd_stamp = rd_data[STAMP_W-1:0];
   assign count_plus = count_ff + LINK_W'(rd_recoverable);

   sfl_slot_mem #(
      .DEPTH  (SLOTS),
      .ADDR_W (ADDR_W),
      .DATA_W (ENTRY_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sfl_recov u_recov (
      .live        (rd_live),
      .stamp       (rd_stamp),
      .published   (pub_ff),
      .recoverable (rd_recoverable)
   );

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      pub_in         = pub_ff;
      ptr_in         = ptr_ff;
      scan_head_in   = scan_head_ff;
      count_in       = count_ff;
      wr_en          = 1'b0;
      wr_addr        = ptr_ff;
      wr_data        = '0;
      rd_en          = 1'b0;
      rd_addr        = ADDR_W'(req_slot_index);
      rsp_valid_in   = 1'b0;
      rsp_status_in  = sfl_pkg::STATUS_DONE;
      rsp_granted_in = '0;
      rsp_count_in   = '0;
      rsp_live_in    = 1'b0;
      rsp_stamp_in   = '0;
      rsp_rec_in     = 1'b0;
      rsp_pub_in     = pub_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = {LINK_W'(ptr_ff) + LINK_W'(1), 1'b0, STAMP_W'(0)};
            ptr_in  = ptr_ff + ADDR_W'(1);
            if (ptr_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rd_en = 1'b1;
               if (req_kind == sfl_pkg::KIND_REBUILD) begin
                  rd_addr      = LAST;
                  ptr_in       = LAST;
                  scan_head_in = EMPTY;
                  count_in     = '0;
                  state_in     = ST_SCAN;
               end else begin
                  if (req_kind == sfl_pkg::KIND_ACQUIRE) begin
                     rd_addr = ADDR_W'(head_ff);
                  end
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            wr_addr      = idx_ff;
            unique case (kind_ff)
               sfl_pkg::KIND_ACQUIRE: begin
                  if (head_empty) begin
                     rsp_status_in = sfl_pkg::STATUS_EMPTY;
                  end else begin
                     rsp_granted_in = sfl_pkg::GRANT_W'(head_ff);
                     head_in        = rd_link;
                  end
               end
               sfl_pkg::KIND_COMMIT: begin
                  if (idx_ok_ff) begin
                     wr_en   = 1'b1;
                     wr_data = {rd_link, 1'b1, seq_ff};
                  end
               end
               sfl_pkg::KIND_RELEASE: begin
                  if (idx_ok_ff) begin
                     wr_en   = 1'b1;
                     wr_data = {head_ff, 1'b0, rd_stamp};
                     head_in = LINK_W'(idx_ff);
                  end
               end
               sfl_pkg::KIND_PUBLISH: begin
                  pub_in     = seq_ff;
                  rsp_pub_in = seq_ff;
               end
               sfl_pkg::KIND_QUERY: begin
                  if (idx_ok_ff) begin
                     rsp_live_in  = rd_live;
                     rsp_stamp_in = rd_stamp;
                     rsp_rec_in   = rd_recoverable;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            // data of slot ptr_ff is present; fetch the slot below it
            rd_en   = (ptr_ff != '0);
            rd_addr = ptr_ff - ADDR_W'(1);
            ptr_in  = ptr_ff - ADDR_W'(1);
            wr_addr = ptr_ff;
            wr_data = {scan_head_ff, 1'b0, rd_stamp};
            count_in = count_plus;
            if (!rd_recoverable) begin
               wr_en        = 1'b1;
               scan_head_in = LINK_W'(ptr_ff);
            end
            if (ptr_ff == '0) begin
               head_in      = scan_head_in;
               rsp_valid_in = 1'b1;
               rsp_count_in = sfl_pkg::COUNT_W'(count_plus);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         head_ff      <= '0;
         pub_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         pub_ff       <= pub_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_head_ff <= scan_head_in;
      count_ff     <= count_in;
      if (accept) begin
         kind_ff   <= req_kind;
         idx_ff    <= ADDR_W'(req_slot_index);
         idx_ok_ff <= req_idx_ok;
         seq_ff    <= req_seq_value;
      end
      if (rsp_valid_in) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_granted_ff <= rsp_granted_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_live_ff    <= rsp_live_in;
         rsp_stamp_ff   <= rsp_stamp_in;
         rsp_rec_ff     <= rsp_rec_in;
         rsp_pub_ff     <= rsp_pub_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_granted_slot     = rsp_granted_ff;
   assign rsp_recovered_count  = rsp_count_ff;
   assign rsp_slot_is_live     = rsp_live_ff;
   assign rsp_slot_stamp       = rsp_stamp_ff;
   assign rsp_slot_recoverable = rsp_rec_ff;
   assign rsp_published_mark   = rsp_pub_ff;

   // a taken request always leaves the block busy in the following cycle
   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("request taken but block not busy");

   // results only leave once the sequencer is back at rest
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe while sequencer active");

   // the clearing pass never produces a result
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> !rsp_valid_ff)
      else $error("result during clearing pass");

   // the free head is a slot or the empty marker
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (int'(head_ff) <= SLOTS))
      else $error("free head out of range");

   // a scan either continues or finishes with a result
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> (rsp_valid_ff || (state_ff == ST_SCAN)))
      else $error("rebuild scan left without result");

endmodule

[hw/rtl/sfl_slot_mem.sv]
// Slot entry memory: one write port, one read port, registered read data.
// Depends on nothing; widths come from the instantiating module.
module sfl_slot_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 74
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sfl_recov.sv]
// Recoverability test of one slot against the published mark.
// Depends on sfl_pkg for the stamp width.
module sfl_recov (
   input  logic                               live,
   input  logic signed [sfl_pkg::STAMP_W-1:0] stamp,
   input  logic signed [sfl_pkg::STAMP_W-1:0] published,
   output logic                               recoverable
);

   assign recoverable = live && (stamp > 0) && (stamp <= published);

endmodule
